// ===== hw/rtl/mip_pkg.sv =====
// Shared types and constants for the maximum intensity projection block.
`default_nettype none
package mip_pkg;

    localparam int COORD_W    = 9;
    localparam int SAMPLE_W   = 16;
    localparam int PEAK_W     = 8;
    localparam int SUM_W      = 18;
    localparam int HEIGHT_W   = 10;
    localparam int CCOUNT_W   = 3;
    localparam int IN_CH      = 4;
    localparam int VOXEL_W    = IN_CH * SAMPLE_W;
    localparam int WIDE_SHIFT = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = 3;
    localparam int QCNT_W     = 4;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd512;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 3'd4;
    localparam logic [PEAK_W-1:0]   PEAK_MAX     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLIP_Y        = 2'd0,
        CFG_WIDE_SAMPLES  = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2,
        CFG_CHANNEL_COUNT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                flip_y;
        logic                wide_samples;
        logic [HEIGHT_W-1:0] image_height;
        logic [CCOUNT_W-1:0] active_ch;    // clamped channel count
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic                first_plane;
        logic                last_plane;
        logic [SAMPLE_W-1:0] chan_a;
        logic [SAMPLE_W-1:0] chan_b;
        logic [SAMPLE_W-1:0] chan_c;
        logic [SAMPLE_W-1:0] chan_d;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [PEAK_W-1:0]  peak_a;
        logic [PEAK_W-1:0]  peak_b;
        logic [PEAK_W-1:0]  peak_c;
        logic [PEAK_W-1:0]  peak_d;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic               inrange;
        logic               first;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SUM_W-1:0]   sum;
        logic [VOXEL_W-1:0] voxel;
    } t_stage;

endpackage
`default_nettype wire

// ===== hw/rtl/mip_if.sv =====
// Valid/ready channel interfaces for voxel input and projection output.
`default_nettype none
interface mip_in_if;
    logic                valid;
    logic                ready;
    mip_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mip_out_if;
    logic                valid;
    logic                ready;
    mip_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mip_prep.sv =====
// Stage 1: range check, store address, channel masking and channel sum.
`default_nettype none
module mip_prep #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int ADDR_W     = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mip_pkg::t_cfg     i_cfg,
    input  wire logic              i_accept,
    input  wire mip_pkg::t_in_item i_item,
    output mip_pkg::t_stage        o_s1,
    output logic [ADDR_W-1:0]      o_s1_addr
);

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);

    mip_pkg::t_stage             r_s1;
    mip_pkg::t_stage             n_s1;
    logic [ADDR_W-1:0]           r_addr;
    logic [ADDR_W-1:0]           n_addr;
    logic [mip_pkg::SAMPLE_W-1:0] samples [mip_pkg::IN_CH];

    assign samples[0] = i_item.chan_a;
    assign samples[1] = i_item.chan_b;
    assign samples[2] = i_item.chan_c;
    assign samples[3] = i_item.chan_d;

    always_comb begin
        n_s1         = '0;
        n_s1.valid   = i_accept;
        n_s1.first   = i_item.first_plane;
        n_s1.last    = i_item.last_plane;
        n_s1.x       = i_item.pixel_x;
        n_s1.y       = i_item.pixel_y;
        n_s1.inrange = (int'(i_item.pixel_x) < MAX_WIDTH) &&
                       (int'(i_item.pixel_y) < MAX_HEIGHT);
        for (int c = 0; c < mip_pkg::IN_CH; c++) begin
            if (mip_pkg::CCOUNT_W'(c) < i_cfg.active_ch) begin
                n_s1.voxel[c*mip_pkg::SAMPLE_W +: mip_pkg::SAMPLE_W] = samples[c];
                n_s1.sum = n_s1.sum + mip_pkg::SUM_W'(samples[c]);
            end
        end
        // exact whenever the pixel is in range, since the store fits ADDR_W
        n_addr = ADDR_W'(i_item.pixel_y) * ROW_STRIDE + ADDR_W'(i_item.pixel_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
        r_addr <= n_addr;
    end

    assign o_s1      = r_s1;
    assign o_s1_addr = r_addr;

endmodule
`default_nettype wire

// ===== hw/rtl/mip_store.sv =====
// Stages 2 and 3: projection store read, compare with forwarding, write back.
`default_nettype none
module mip_store #(
    parameter int DEPTH   = 262144,
    parameter int ADDR_W  = 18,
    parameter int STORE_W = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mip_pkg::t_stage i_s1,
    input  wire logic [ADDR_W-1:0] i_s1_addr,
    output mip_pkg::t_stage      o_s3
);

    localparam int ENTRY_W = mip_pkg::SUM_W + STORE_W;

    logic [ENTRY_W-1:0] mem [DEPTH];

    mip_pkg::t_stage              r_s2;
    logic [ADDR_W-1:0]            r_s2_addr;
    logic [ENTRY_W-1:0]           r_rd;
    logic                         r_fwd;
    logic [mip_pkg::SUM_W-1:0]    r_fwd_sum;
    logic [mip_pkg::VOXEL_W-1:0]  r_fwd_vox;
    mip_pkg::t_stage              r_s3;

    logic [mip_pkg::SUM_W-1:0]    old_sum;
    logic [mip_pkg::VOXEL_W-1:0]  old_vox;
    logic                         upd;
    logic                         wr_en;
    logic [mip_pkg::SUM_W-1:0]    kept_sum;
    logic [mip_pkg::VOXEL_W-1:0]  kept_vox;
    mip_pkg::t_stage              n_s3;

    always_comb begin
        // the item one stage ahead writes at the same edge this one reads
        if (r_fwd) begin
            old_sum = r_fwd_sum;
            old_vox = r_fwd_vox;
        end else begin
            old_sum = r_rd[ENTRY_W-1 -: mip_pkg::SUM_W];
            old_vox = mip_pkg::VOXEL_W'(r_rd[STORE_W-1:0]);
        end
        upd      = r_s2.first || (r_s2.sum > old_sum);
        wr_en    = r_s2.valid && r_s2.inrange && upd;
        kept_sum = upd ? r_s2.sum : old_sum;
        kept_vox = upd ? r_s2.voxel : old_vox;
        n_s3       = r_s2;
        n_s3.sum   = kept_sum;
        n_s3.voxel = kept_vox;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_s1_addr];
        if (wr_en) begin
            mem[r_s2_addr] <= {kept_sum, r_s2.voxel[STORE_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s2  <= i_s1;
            r_s3  <= n_s3;
            r_fwd <= r_s2.valid && r_s2.inrange && (r_s2_addr == i_s1_addr);
        end
        r_s2_addr <= i_s1_addr;
        r_fwd_sum <= kept_sum;
        r_fwd_vox <= kept_vox;
    end

    assign o_s3 = r_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/mip_format.sv =====
// Output formatting: scale wide samples, saturate and mask channels, mirror the row when flip_y is set.
`default_nettype none
module mip_format (
    input  wire mip_pkg::t_stage i_s3,
    input  wire mip_pkg::t_cfg   i_cfg,
    output logic                 o_push,
    output logic                 o_drop,
    output mip_pkg::t_out_item   o_item
);

    logic [mip_pkg::PEAK_W-1:0]   peaks [mip_pkg::IN_CH];
    logic [mip_pkg::SAMPLE_W-1:0] v;
    logic [mip_pkg::HEIGHT_W-1:0] mirrored;

    always_comb begin
        for (int c = 0; c < mip_pkg::IN_CH; c++) begin
            v = i_s3.voxel[c*mip_pkg::SAMPLE_W +: mip_pkg::SAMPLE_W];
            if (i_cfg.wide_samples) begin
                v = v >> mip_pkg::WIDE_SHIFT;
            end
            if (mip_pkg::CCOUNT_W'(c) >= i_cfg.active_ch) begin
                peaks[c] = '0;
            end else if (v > mip_pkg::SAMPLE_W'(mip_pkg::PEAK_MAX)) begin
                peaks[c] = mip_pkg::PEAK_MAX;
            end else begin
                peaks[c] = v[mip_pkg::PEAK_W-1:0];
            end
        end
        mirrored = i_cfg.image_height - mip_pkg::HEIGHT_W'(i_s3.y) - 10'd1;
    end

    assign o_push        = i_s3.valid && i_s3.inrange && i_s3.last;
    assign o_drop        = i_s3.valid && !(i_s3.inrange && i_s3.last);
    assign o_item.out_x  = i_s3.x;
    assign o_item.out_y  = i_cfg.flip_y ? mirrored[mip_pkg::COORD_W-1:0] : i_s3.y;
    assign o_item.peak_a = peaks[0];
    assign o_item.peak_b = peaks[1];
    assign o_item.peak_c = peaks[2];
    assign o_item.peak_d = peaks[3];

endmodule
`default_nettype wire

// ===== hw/rtl/mip_fifo.sv =====
// Output queue that decouples the pipeline from the result consumer.
`default_nettype none
module mip_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire mip_pkg::t_out_item  i_item,
    mip_out_if.source                o_out
);

    mip_pkg::t_out_item          r_q [mip_pkg::QDEPTH];
    logic [mip_pkg::QPTR_W-1:0]  r_wr;
    logic [mip_pkg::QPTR_W-1:0]  r_rd;
    logic [mip_pkg::QCNT_W-1:0]  r_count;
    logic                        pop;

    assign pop         = o_out.valid && o_out.ready;
    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + mip_pkg::QCNT_W'(i_push) - mip_pkg::QCNT_W'(pop);
        end
        if (i_push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/max_intensity_projection_top.sv =====
// Top level of the maximum intensity projection block.
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          pixel_x, pixel_y, plane marks, chan_a..chan_d
//  o_out     out  valid/ready          out_x, out_y, peak_a..peak_d
//  cfg       in   i_cfg_we (no wait)   i_cfg_idx, i_cfg_data
//
// One voxel per cycle sustained while i_in.ready is high; a result is offered on
// o_out after the prep, store read, compare and queue registers. The rate is set by
// the single read-compare-write per voxel on the store, previous update forwarded.
// Reset clears control only; the store holds garbage until plane zero loads it.
// Input ready drops only when the 8-entry output queue could fill with voxels
// already in flight; the core pipeline itself never stalls.
`default_nettype none
module max_intensity_projection_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int CHANNELS   = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mip_in_if.sink                                 i_in,
    mip_out_if.source                              o_out
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VOX_CH  = (CHANNELS < mip_pkg::IN_CH) ? CHANNELS : mip_pkg::IN_CH;
    localparam int STORE_W = VOX_CH * mip_pkg::SAMPLE_W;

    logic                          r_flip_y;
    logic                          r_wide;
    logic [mip_pkg::HEIGHT_W-1:0]  r_height;
    logic [mip_pkg::CCOUNT_W-1:0]  r_ccount;
    logic [mip_pkg::CCOUNT_W-1:0]  active_ch;
    mip_pkg::t_cfg                 cfg;

    logic [mip_pkg::QCNT_W-1:0]    r_inflight;
    logic                          accept;
    logic                          pop;
    logic                          push;
    logic                          drop;

    mip_pkg::t_stage               s1;
    logic [ADDR_W-1:0]             s1_addr;
    mip_pkg::t_stage               s3;
    mip_pkg::t_out_item            fmt_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_y <= 1'b0;
            r_wide   <= 1'b0;
            r_height <= mip_pkg::HEIGHT_RESET;
            r_ccount <= mip_pkg::CCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (mip_pkg::t_cfg_reg'(i_cfg_idx))
                mip_pkg::CFG_FLIP_Y:        r_flip_y <= i_cfg_data[0];
                mip_pkg::CFG_WIDE_SAMPLES:  r_wide   <= i_cfg_data[0];
                mip_pkg::CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[mip_pkg::HEIGHT_W-1:0];
                mip_pkg::CFG_CHANNEL_COUNT: r_ccount <= i_cfg_data[mip_pkg::CCOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // zero counts as one channel; clamp to the input lanes and the build
    always_comb begin
        active_ch = r_ccount;
        if (active_ch == '0) begin
            active_ch = mip_pkg::CCOUNT_W'(1);
        end
        if (active_ch > mip_pkg::CCOUNT_W'(VOX_CH)) begin
            active_ch = mip_pkg::CCOUNT_W'(VOX_CH);
        end
        cfg.flip_y       = r_flip_y;
        cfg.wide_samples = r_wide;
        cfg.image_height = r_height;
        cfg.active_ch    = active_ch;
    end

    // credits: every transfer in flight has a queue slot reserved
    assign i_in.ready = (r_inflight < mip_pkg::QCNT_W'(mip_pkg::QDEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + mip_pkg::QCNT_W'(accept)
                        - mip_pkg::QCNT_W'(drop) - mip_pkg::QCNT_W'(pop);
        end
    end

    mip_prep #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_item    (i_in.data),
        .o_s1      (s1),
        .o_s1_addr (s1_addr)
    );

    mip_store #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .STORE_W (STORE_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_s1_addr (s1_addr),
        .o_s3      (s3)
    );

    mip_format u_format (
        .i_s3   (s3),
        .i_cfg  (cfg),
        .o_push (push),
        .o_drop (drop),
        .o_item (fmt_item)
    );

    mip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fmt_item),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
